/* sv/pse_pkg.sv */
// Shared constants, types and the control store of the prime sieve engine.
package pse_pkg;

  // Sizing of the stores.
  localparam int MAX_LIMIT = 65536;
  localparam int LIST_DEPTH = 8192;
  localparam int MAP_AW = $clog2(MAX_LIMIT);
  localparam int LIST_AW = $clog2(LIST_DEPTH);
  localparam int LIM_W = $clog2(MAX_LIMIT + 1);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int SQ_W = 2 * LIM_W;

  // Field widths of the channels and the configuration register.
  localparam int CFG_W = 17;
  localparam int MODE_W = 2;
  localparam int IDX_W = 13;
  localparam int VAL_W = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 13;
  localparam int PVAL_W = 16;
  localparam int SIEVE_LIMIT_RST = 65536;

  // Widths used when comparing fields of different sizes.
  localparam int LCMP_W = (CFG_W > LIM_W) ? CFG_W : LIM_W;
  localparam int VCMP_W = (VAL_W > LIM_W) ? VAL_W : LIM_W;
  localparam int IDXC_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_BUILD = 2'd0,
    MODE_FETCH = 2'd1,
    MODE_TEST  = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_BUILT = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  // Kind of result loaded into the output register.
  typedef enum logic [2:0] {
    K_BUILD,
    K_FETCH,
    K_TEST,
    K_NOT_BUILT,
    K_RANGE
  } kind_t;

  // Microprogram steps.
  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR_INIT,
    S_CLR,
    S_I_INIT,
    S_SQ,
    S_SQ_TEST,
    S_MARK_INIT,
    S_MARK,
    S_NEXT_I,
    S_COL_INIT,
    S_COL_RD,
    S_COL_CHK,
    S_BUILD_DONE,
    S_FETCH_CHK,
    S_FETCH_RD,
    S_FETCH_OUT,
    S_TEST_CHK,
    S_TEST_RD,
    S_TEST_OUT,
    S_NOT_BUILT,
    S_BAD
  } step_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER,
    C_TRUE,
    C_NO_IN,
    C_J_GE_LIM,
    C_SQ_GE_LIM,
    C_MAP_SET,
    C_COL_DONE,
    C_NOT_BUILT,
    C_IDX_GE_CNT,
    C_VAL_GE_BL,
    C_OUT_BUSY
  } cond_t;

  // Sequencing when the condition does not hold.
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_HOLD,
    SEQ_DISP,
    SEQ_IDLE
  } seq_t;

  // Datapath actions of one step.
  typedef struct packed {
    logic  accept;
    logic  j_clr;
    logic  j_inc;
    logic  j_from_sq;
    logic  j_add_i;
    logic  i_init;
    logic  i_inc;
    logic  sq_calc;
    logic  map_clr;
    logic  map_set;
    logic  map_rd_i;
    logic  map_rd_val;
    logic  list_wr;
    logic  cnt_clr;
    logic  list_rd;
    logic  built_set;
    logic  out_load;
    kind_t kind;
  } ctl_t;

  // One control word of the store.
  typedef struct packed {
    cond_t cond;
    step_t target;
    seq_t  seq;
    logic  gate;
    logic  ready;
    ctl_t  ctl;
  } uword_t;

  // Status flags returned by the datapath.
  typedef struct packed {
    logic  in_valid;
    mode_t mode;
    logic  j_ge_lim;
    logic  sq_ge_lim;
    logic  map_set;
    logic  col_done;
    logic  not_built;
    logic  idx_ge_cnt;
    logic  val_ge_bl;
    logic  out_busy;
  } flags_t;

  // When gate is set, the actions of a step are dropped in a cycle whose jump is taken.
  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    w = '0;
    w.cond = C_NEVER;
    w.target = S_IDLE;
    w.seq = SEQ_NEXT;
    w.ctl.kind = K_BUILD;
    unique case (s)
      S_IDLE: begin
        w.cond = C_NO_IN; w.target = S_IDLE; w.seq = SEQ_DISP;
        w.gate = 1'b1; w.ready = 1'b1; w.ctl.accept = 1'b1;
      end
      S_CLR_INIT: begin
        w.ctl.j_clr = 1'b1;
      end
      S_CLR: begin
        w.cond = C_J_GE_LIM; w.target = S_I_INIT; w.seq = SEQ_HOLD; w.gate = 1'b1;
        w.ctl.map_clr = 1'b1; w.ctl.j_inc = 1'b1;
      end
      S_I_INIT: begin
        w.ctl.i_init = 1'b1;
      end
      S_SQ: begin
        w.ctl.sq_calc = 1'b1; w.ctl.map_rd_i = 1'b1;
      end
      S_SQ_TEST: begin
        w.cond = C_SQ_GE_LIM; w.target = S_COL_INIT;
      end
      S_MARK_INIT: begin
        w.cond = C_MAP_SET; w.target = S_NEXT_I; w.gate = 1'b1;
        w.ctl.j_from_sq = 1'b1;
      end
      S_MARK: begin
        w.cond = C_J_GE_LIM; w.target = S_NEXT_I; w.seq = SEQ_HOLD; w.gate = 1'b1;
        w.ctl.map_set = 1'b1; w.ctl.j_add_i = 1'b1;
      end
      S_NEXT_I: begin
        w.cond = C_TRUE; w.target = S_SQ;
        w.ctl.i_inc = 1'b1;
      end
      S_COL_INIT: begin
        w.ctl.i_init = 1'b1; w.ctl.cnt_clr = 1'b1;
      end
      S_COL_RD: begin
        w.cond = C_COL_DONE; w.target = S_BUILD_DONE; w.gate = 1'b1;
        w.ctl.map_rd_i = 1'b1;
      end
      S_COL_CHK: begin
        w.cond = C_TRUE; w.target = S_COL_RD;
        w.ctl.list_wr = 1'b1; w.ctl.i_inc = 1'b1;
      end
      S_BUILD_DONE: begin
        w.cond = C_OUT_BUSY; w.target = S_BUILD_DONE; w.seq = SEQ_IDLE; w.gate = 1'b1;
        w.ctl.built_set = 1'b1; w.ctl.out_load = 1'b1; w.ctl.kind = K_BUILD;
      end
      S_FETCH_CHK: begin
        w.cond = C_NOT_BUILT; w.target = S_NOT_BUILT;
      end
      S_FETCH_RD: begin
        w.cond = C_IDX_GE_CNT; w.target = S_BAD; w.gate = 1'b1;
        w.ctl.list_rd = 1'b1;
      end
      S_FETCH_OUT: begin
        w.cond = C_OUT_BUSY; w.target = S_FETCH_OUT; w.seq = SEQ_IDLE; w.gate = 1'b1;
        w.ctl.out_load = 1'b1; w.ctl.kind = K_FETCH;
      end
      S_TEST_CHK: begin
        w.cond = C_NOT_BUILT; w.target = S_NOT_BUILT;
      end
      S_TEST_RD: begin
        w.cond = C_VAL_GE_BL; w.target = S_BAD; w.gate = 1'b1;
        w.ctl.map_rd_val = 1'b1;
      end
      S_TEST_OUT: begin
        w.cond = C_OUT_BUSY; w.target = S_TEST_OUT; w.seq = SEQ_IDLE; w.gate = 1'b1;
        w.ctl.out_load = 1'b1; w.ctl.kind = K_TEST;
      end
      S_NOT_BUILT: begin
        w.cond = C_OUT_BUSY; w.target = S_NOT_BUILT; w.seq = SEQ_IDLE; w.gate = 1'b1;
        w.ctl.out_load = 1'b1; w.ctl.kind = K_NOT_BUILT;
      end
      S_BAD: begin
        w.cond = C_OUT_BUSY; w.target = S_BAD; w.seq = SEQ_IDLE; w.gate = 1'b1;
        w.ctl.out_load = 1'b1; w.ctl.kind = K_RANGE;
      end
      default: begin
        w.seq = SEQ_IDLE;
      end
    endcase
    return w;
  endfunction

  // Entry step of each item mode.
  function automatic step_t dispatch(mode_t m);
    step_t s;
    s = S_BAD;
    unique case (m)
      MODE_BUILD: s = S_CLR_INIT;
      MODE_FETCH: s = S_FETCH_CHK;
      MODE_TEST:  s = S_TEST_CHK;
      MODE_RSVD:  s = S_BAD;
      default:    s = S_BAD;
    endcase
    return s;
  endfunction

endpackage

/* sv/pse_in_if.sv */
// Item channel of the prime sieve engine: valid, ready and the item fields.
interface pse_in_if import pse_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [IDX_W-1:0]   prime_index;
  logic [VAL_W-1:0]   test_value;

  modport source (output valid, output mode, output prime_index, output test_value,
                  input ready);
  modport sink (input valid, input mode, input prime_index, input test_value,
                output ready);
endinterface

/* sv/pse_out_if.sv */
// Result channel of the prime sieve engine: valid, ready and the result fields.
interface pse_out_if import pse_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  prime_count;
  logic [PVAL_W-1:0]   prime_value;
  logic                is_prime;

  modport source (output valid, output status, output prime_count, output prime_value,
                  output is_prime, input ready);
  modport sink (input valid, input status, input prime_count, input prime_value,
                input is_prime, output ready);
endinterface

/* sv/pse_useq.sv */
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
module pse_useq import pse_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output ctl_t   ctl,
  output logic   ready
);

  step_t  upc;
  step_t  upc_next;
  uword_t uw;
  logic   hit;
  logic   act;

  always_comb begin
    uw = ucode_rom(upc);
  end

  always_comb begin
    unique case (uw.cond)
      C_NEVER:      hit = 1'b0;
      C_TRUE:       hit = 1'b1;
      C_NO_IN:      hit = !flags.in_valid;
      C_J_GE_LIM:   hit = flags.j_ge_lim;
      C_SQ_GE_LIM:  hit = flags.sq_ge_lim;
      C_MAP_SET:    hit = flags.map_set;
      C_COL_DONE:   hit = flags.col_done;
      C_NOT_BUILT:  hit = flags.not_built;
      C_IDX_GE_CNT: hit = flags.idx_ge_cnt;
      C_VAL_GE_BL:  hit = flags.val_ge_bl;
      C_OUT_BUSY:   hit = flags.out_busy;
      default:      hit = 1'b0;
    endcase
  end

  // A gated step acts only in the cycles where it does not jump.
  always_comb begin
    act = !uw.gate || !hit;
    ctl = act ? uw.ctl : '0;
    ready = uw.ready;
  end

  always_comb begin
    if (hit) begin
      upc_next = uw.target;
    end else begin
      unique case (uw.seq)
        SEQ_NEXT: upc_next = step_t'(5'(upc) + 5'd1);
        SEQ_HOLD: upc_next = upc;
        SEQ_DISP: upc_next = dispatch(flags.mode);
        SEQ_IDLE: upc_next = S_IDLE;
        default:  upc_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

/* sv/pse_dpath.sv */
// Datapath: limit register, loop registers, bitmap and prime list memories, result register.
module pse_dpath import pse_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ctl_t                ctl,
  output flags_t              flags,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic                in_valid,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [IDX_W-1:0]    in_prime_index,
  input  logic [VAL_W-1:0]    in_test_value,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_prime_count,
  output logic [PVAL_W-1:0]   out_prime_value,
  output logic                out_is_prime
);

  logic [CFG_W-1:0]  sieve_limit;
  logic [LIM_W-1:0]  eff_lim;
  logic [LIM_W-1:0]  lim;
  logic [IDX_W-1:0]  idx;
  logic [VAL_W-1:0]  val;
  logic [LIM_W-1:0]  i;
  logic [LIM_W-1:0]  j;
  logic [SQ_W-1:0]   sq;
  logic [CNT_W-1:0]  cnt;
  logic              built;
  logic [LIM_W-1:0]  built_lim;

  logic              map_mem [MAX_LIMIT];
  logic              map_q;
  logic              map_we;
  logic [MAP_AW-1:0] map_ra;
  logic [PVAL_W-1:0] list_mem [LIST_DEPTH];
  logic [PVAL_W-1:0] list_q;
  logic              list_we;
  logic              test_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sieve_limit <= CFG_W'(SIEVE_LIMIT_RST);
    end else if (cfg_wr_en) begin
      sieve_limit <= cfg_wr_data;
    end
  end

  always_comb begin
    if (LCMP_W'(sieve_limit) > LCMP_W'(MAX_LIMIT)) begin
      eff_lim = LIM_W'(MAX_LIMIT);
    end else begin
      eff_lim = LIM_W'(sieve_limit);
    end
  end

  // The limit is taken with every item, so a later register write waits for the next build.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      idx <= in_prime_index;
      val <= in_test_value;
      lim <= eff_lim;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.i_init) begin
      i <= LIM_W'(2);
    end else if (ctl.i_inc) begin
      i <= i + LIM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    priority if (ctl.j_clr) begin
      j <= '0;
    end else if (ctl.j_inc) begin
      j <= j + LIM_W'(1);
    end else if (ctl.j_from_sq) begin
      j <= LIM_W'(sq);
    end else if (ctl.j_add_i) begin
      j <= j + i;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sq_calc) begin
      sq <= SQ_W'(i) * SQ_W'(i);
    end
  end

  // Bitmap: cleared and marked at the loop index, read at the base or the tested value.
  assign map_we = ctl.map_clr || ctl.map_set;
  assign map_ra = ctl.map_rd_val ? MAP_AW'(val) : MAP_AW'(i);

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[MAP_AW'(j)] <= ctl.map_set;
    end
    if (ctl.map_rd_i || ctl.map_rd_val) begin
      map_q <= map_mem[map_ra];
    end
  end

  // A value is stored during collection only when its bitmap entry is clear.
  assign list_we = ctl.list_wr && !map_q;

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[cnt[LIST_AW-1:0]] <= PVAL_W'(i);
    end
    if (ctl.list_rd) begin
      list_q <= list_mem[LIST_AW'(IDXC_W'(idx))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      built <= 1'b0;
      built_lim <= '0;
    end else begin
      if (ctl.cnt_clr) begin
        cnt <= '0;
      end else if (list_we) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (ctl.built_set) begin
        built <= 1'b1;
        built_lim <= lim;
      end
    end
  end

  always_comb begin
    flags.in_valid = in_valid;
    flags.mode = mode_t'(in_mode);
    flags.j_ge_lim = (j >= lim);
    flags.sq_ge_lim = (sq >= SQ_W'(lim));
    flags.map_set = map_q;
    flags.col_done = (i >= lim) || (cnt >= CNT_W'(LIST_DEPTH));
    flags.not_built = !built;
    flags.idx_ge_cnt = (IDXC_W'(idx) >= IDXC_W'(cnt));
    flags.val_ge_bl = (VCMP_W'(val) >= VCMP_W'(built_lim));
    flags.out_busy = out_valid && !out_ready;
  end

  assign test_hit = (val >= VAL_W'(2)) && !map_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_prime_count <= COUNT_W'(cnt);
      out_prime_value <= '0;
      out_is_prime <= 1'b0;
      unique case (ctl.kind)
        K_BUILD: begin
          out_status <= ST_OK;
        end
        K_FETCH: begin
          out_status <= ST_OK;
          out_prime_value <= list_q;
        end
        K_TEST: begin
          out_status <= ST_OK;
          out_is_prime <= test_hit;
        end
        K_NOT_BUILT: begin
          out_status <= ST_NOT_BUILT;
        end
        K_RANGE: begin
          out_status <= ST_RANGE;
        end
        default: begin
          out_status <= ST_RANGE;
        end
      endcase
    end
  end

endmodule

/* sv/prime_sieve_engine.sv */
// Top level of the prime sieve engine: microcoded sequencer driving the sieve datapath.
//
// Items arrive on the query channel and one result per item leaves on the result
// channel; each channel moves a transaction when valid and ready are both high.
// Mode 0 builds the sieve below min(sieve_limit, 65536), mode 1 fetches the prime at
// prime_index, mode 2 tests test_value; other modes answer with a range status.
// cfg_wr_en writes sieve_limit; the new limit applies from the next build.
// The block takes one item at a time: query.ready is high only while the sequencer
// waits for work. A fetch or test passes its check, read and output steps before its
// result shows, and the next item is taken once the sequencer is back at its idle step.
// A query before any build skips the read step, and an unknown mode goes straight to
// its output step. A build clears the bitmap, marks the multiples of each base that is
// still unmarked and whose square lies below the limit, then collects the values whose
// bitmap entry is clear into the prime list until it is full; the sequencer does one
// step per cycle and waits only at an output step while the receiver stalls.
// Reset empties the result register, sets sieve_limit to 65536 and marks the sieve as
// not built; there is no clearing pass, as a build clears what it will later read.
// When the receiver stalls, the result register holds its transaction and the
// sequencer waits at its output step; the item under way is not lost.
module prime_sieve_engine import pse_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  pse_in_if.sink           query,
  pse_out_if.source        result
);

  ctl_t   ctl;
  flags_t flags;
  logic   seq_ready;

  pse_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl),
    .ready (seq_ready)
  );

  pse_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .flags           (flags),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (query.valid),
    .in_mode         (query.mode),
    .in_prime_index  (query.prime_index),
    .in_test_value   (query.test_value),
    .out_ready       (result.ready),
    .out_valid       (result.valid),
    .out_status      (result.status),
    .out_prime_count (result.prime_count),
    .out_prime_value (result.prime_value),
    .out_is_prime    (result.is_prime)
  );

  assign query.ready = seq_ready;

endmodule

/* sv/pse_checker.sv */
// Port-level checks of the prime sieve engine and their binding to the top level.
module pse_checker import pse_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                q_valid,
  input logic                q_ready,
  input logic                r_valid,
  input logic                r_ready,
  input logic [STATUS_W-1:0] r_status,
  input logic [COUNT_W-1:0]  r_count,
  input logic [PVAL_W-1:0]   r_value,
  input logic                r_is_prime
);

  // The result channel is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !r_valid)
    else $error("result valid after reset");

  // One item at a time: the block closes its input after taking a transaction.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |=> !q_ready)
    else $error("query accepted while an item is under way");

  // A stalled result holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (r_valid && !r_ready) |=> (r_valid && $stable(r_status) && $stable(r_count)
                               && $stable(r_value) && $stable(r_is_prime)))
    else $error("stalled result changed");

  // A failed query carries no prime and no primality flag.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (r_valid && r_status != ST_OK) |-> (r_value == '0 && !r_is_prime))
    else $error("failed query returned data");

  // A result never carries both a fetched prime and a test answer.
  a_one_answer: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> !(r_is_prime && r_value != '0))
    else $error("result carries both a prime and a test answer");

endmodule

bind prime_sieve_engine pse_checker u_pse_checker (
  .clk        (clk),
  .rst        (rst),
  .q_valid    (query.valid),
  .q_ready    (query.ready),
  .r_valid    (result.valid),
  .r_ready    (result.ready),
  .r_status   (result.status),
  .r_count    (result.prime_count),
  .r_value    (result.prime_value),
  .r_is_prime (result.is_prime)
);
